// ===== rtl/core/csvft_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
// Holds the beat structs, result codes, character codes and the field state.
// No dependencies.
package csvft_pkg;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ERROR     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FT_EMPTY   = 3'd0,
    FT_INTEGER = 3'd1,
    FT_FLOAT   = 3'd2,
    FT_QUOTED  = 3'd3,
    FT_PLAIN   = 3'd4
  } field_type_t;

  typedef enum logic [1:0] {
    RADIX_NONE = 2'd0,
    RADIX_DEC  = 2'd1,
    RADIX_OCT  = 2'd2
  } radix_t;

  typedef enum logic {
    CMD_TEXT    = 1'b0,
    CMD_DOC_END = 1'b1
  } command_t;

  typedef struct packed {
    command_t    command;
    logic [7:0]  text_byte;
  } in_beat_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         content_byte;
    field_type_t        field_type;
    logic signed [63:0] int_value;
    logic               row_end;
    logic               doc_end;
  } out_beat_t;

  typedef struct packed {
    logic        inside_quotes;
    logic        field_quoted;
    logic        maybe_integer;
    logic        maybe_float;
    logic        field_started;
    logic        negative_sign;
    radix_t      radix_state;
    logic        digits_stopped;
    logic [63:0] magnitude;
    logic        overflowed;
    logic        error_hold;
  } field_state_t;

  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharQuote   = 8'h22;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  localparam logic [63:0] LimitMag  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos    = LimitMag - 64'd1;
  // Largest magnitude that still takes one more digit without passing LimitMag.
  localparam logic [63:0] DecLimitHi = (LimitMag - 64'd8) / 64'd10;
  localparam logic [63:0] DecLimitLo = (LimitMag - 64'd9) / 64'd10;
  localparam logic [63:0] OctLimitHi = LimitMag / 64'd8;
  localparam logic [63:0] OctLimitLo = (LimitMag - 64'd1) / 64'd8;

  localparam field_state_t StateReset = '{
    inside_quotes:  1'b0,
    field_quoted:   1'b0,
    maybe_integer:  1'b1,
    maybe_float:    1'b1,
    field_started:  1'b0,
    negative_sign:  1'b0,
    radix_state:    RADIX_NONE,
    digits_stopped: 1'b0,
    magnitude:      64'd0,
    overflowed:     1'b0,
    error_hold:     1'b0
  };

endpackage

// ===== rtl/core/csv_field_tokenizer_top.sv =====
// Top level of the CSV field tokenizer: field state register and result register.
// Depends on csvft_pkg and csvft_step.
//
//   channel   direction  payload     handshake
//   byte      in         in_beat_t   byte_valid / byte_ready
//   token     out        out_beat_t  token_valid / token_ready
//
// One byte beat is taken per cycle while byte_ready is high; its result, if any, shows on token the next cycle.
// The field state updates in the cycle of acceptance, so a run of beats needs no gaps.
// byte_ready drops only while a result waits in the output register and token_ready is low.
// Synchronous reset clears the field state and empties the output register.
module csv_field_tokenizer_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  csvft_pkg::in_beat_t  byte_beat,
  output logic                 token_valid,
  input  logic                 token_ready,
  output csvft_pkg::out_beat_t token_beat
);
  import csvft_pkg::*;

  field_state_t state;
  field_state_t state_next;
  logic         step_emit;
  out_beat_t    step_result;
  logic         accept;

  csvft_step u_step (
    .state      (state),
    .beat       (byte_beat),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  assign byte_ready = !token_valid || token_ready;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= StateReset;
      token_valid <= 1'b0;
    end else begin
      if (accept) begin
        state       <= state_next;
        token_valid <= step_emit;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_emit) begin
      token_beat <= step_result;
    end
  end

endmodule

// ===== rtl/core/csvft_step.sv =====
// Per-byte update of the CSV field tokenizer: next field state and the result beat.
// Purely combinational; depends on csvft_pkg.
module csvft_step (
  input  csvft_pkg::field_state_t state,
  input  csvft_pkg::in_beat_t     beat,
  output csvft_pkg::field_state_t state_next,
  output logic                    emit,
  output csvft_pkg::out_beat_t    result
);
  import csvft_pkg::*;

  function automatic field_state_t clear_field(input field_state_t s);
    field_state_t r;
    r               = StateReset;
    r.inside_quotes = s.inside_quotes;
    r.error_hold    = s.error_hold;
    return r;
  endfunction

  function automatic logic [63:0] int_result(input field_state_t s);
    logic [63:0] r;
    if (s.negative_sign) begin
      r = s.overflowed ? LimitMag : (64'd0 - s.magnitude);
    end else if (s.overflowed || s.magnitude[63]) begin
      r = MaxPos;
    end else begin
      r = s.magnitude;
    end
    return r;
  endfunction

  function automatic out_beat_t field_record(input field_state_t s, input logic row,
                                             input logic doc);
    out_beat_t r;
    r         = '0;
    r.kind    = KIND_FIELD_END;
    r.row_end = row;
    r.doc_end = doc;
    if (!s.field_started) begin
      r.field_type = FT_EMPTY;
    end else if (s.maybe_integer) begin
      r.field_type = FT_INTEGER;
      r.int_value  = int_result(s);
    end else if (s.maybe_float) begin
      r.field_type = FT_FLOAT;
    end else if (s.field_quoted) begin
      r.field_type = FT_QUOTED;
    end else begin
      r.field_type = FT_PLAIN;
    end
    return r;
  endfunction

  logic [7:0]   c;
  logic [3:0]   d;
  logic         is_digit;
  logic         quoted_now;
  logic         content;
  logic         mi;
  logic [63:0]  mag_limit;
  logic [63:0]  mag_scaled;
  field_state_t s;

  assign c        = beat.text_byte;
  assign d        = c[3:0];
  assign is_digit = (c >= CharZero) && (c <= CharNine);

  always_comb begin
    if (state.radix_state == RADIX_OCT) begin
      mag_limit  = (d == 4'd0) ? OctLimitHi : OctLimitLo;
      mag_scaled = {state.magnitude[60:0], 3'b000} + {60'd0, d};
    end else begin
      mag_limit  = (d == 4'd9) ? DecLimitLo : DecLimitHi;
      mag_scaled = {state.magnitude[60:0], 3'b000} + {state.magnitude[62:0], 1'b0}
                   + {60'd0, d};
    end
  end

  always_comb begin
    s          = state;
    emit       = 1'b0;
    result     = '0;
    quoted_now = 1'b0;
    content    = 1'b0;
    mi         = 1'b0;
    if (beat.command == CMD_DOC_END) begin
      s = StateReset;
      if (!state.error_hold) begin
        emit = 1'b1;
        if (state.inside_quotes) begin
          result.kind    = KIND_ERROR;
          result.doc_end = 1'b1;
        end else begin
          result = field_record(state, 1'b1, 1'b1);
        end
      end
    end else if (state.error_hold) begin
      s = state;
    end else if (!state.inside_quotes && (c == CharComma || c == CharNewline)) begin
      emit   = 1'b1;
      result = field_record(state, c == CharNewline, 1'b0);
      s      = clear_field(state);
    end else if (c != CharQuote && state.field_quoted && !state.inside_quotes) begin
      emit         = 1'b1;
      result.kind  = KIND_ERROR;
      s.error_hold = 1'b1;
    end else begin
      if (c == CharQuote) begin
        quoted_now     = state.field_quoted || !state.field_started;
        s.field_quoted = quoted_now;
        if (quoted_now) begin
          content         = !state.inside_quotes && state.field_started;
          s.inside_quotes = !state.inside_quotes;
        end else begin
          content = 1'b1;
        end
      end else begin
        content = 1'b1;
      end

      if (state.maybe_float && !is_digit && (state.field_started || c != CharMinus)) begin
        if (c == CharDot) begin
          if (state.maybe_integer) begin
            s.maybe_integer = 1'b0;
          end else begin
            s.maybe_float = 1'b0;
          end
        end else begin
          s.maybe_integer = 1'b0;
          s.maybe_float   = 1'b0;
        end
      end
      mi = s.maybe_integer;

      if (mi) begin
        if (is_digit) begin
          if (state.radix_state == RADIX_NONE) begin
            s.radix_state = (d == 4'd0) ? RADIX_OCT : RADIX_DEC;
            s.magnitude   = {60'd0, d};
          end else if (state.digits_stopped) begin
            s.digits_stopped = 1'b1;
          end else if (state.radix_state == RADIX_OCT && d[3]) begin
            s.digits_stopped = 1'b1;
          end else if (!state.overflowed) begin
            if (state.magnitude > mag_limit) begin
              s.overflowed = 1'b1;
            end else begin
              s.magnitude = mag_scaled;
            end
          end
        end else if (c == CharMinus && !state.field_started) begin
          s.negative_sign = 1'b1;
        end
      end

      s.field_started = 1'b1;
      if (content) begin
        emit                = 1'b1;
        result.kind         = KIND_CONTENT;
        result.content_byte = c;
      end
    end
    state_next = s;
  end

endmodule

// ===== rtl/core/csvft_checker.sv =====
// Port-level checks for the CSV field tokenizer, bound to the top level.
// Depends on csvft_pkg and csv_field_tokenizer_top.
module csvft_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_ready,
  input logic                 token_valid,
  input logic                 token_ready,
  input csvft_pkg::out_beat_t token_beat
);
  import csvft_pkg::*;

  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_beat))
    else $error("token beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !token_valid |-> byte_ready)
    else $error("byte channel stalled with an empty output register");

  a_content_clean: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_beat.kind == KIND_CONTENT |->
      token_beat.field_type == FT_EMPTY && token_beat.int_value == 64'sd0 &&
      !token_beat.row_end && !token_beat.doc_end)
    else $error("content beat carries record fields");

  a_doc_end_row_end: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_beat.kind == KIND_FIELD_END && token_beat.doc_end |->
      token_beat.row_end)
    else $error("final field record without row end");

  a_value_only_integer: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_beat.field_type != FT_INTEGER |-> token_beat.int_value == 64'sd0)
    else $error("nonzero value on a non-integer beat");

endmodule

bind csv_field_tokenizer_top csvft_checker u_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for csv_field_tokenizer_top: directed table, then random CSV documents.
// Expected token beats come from a behavioral tokenizer model kept in this file, or from the row itself for typed rows.
// Depends on csvft_pkg and csv_field_tokenizer_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csvft_pkg::*;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } script_row_t;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_ready;
  in_beat_t  byte_beat;
  logic      token_valid;
  logic      token_ready;
  out_beat_t token_beat;

  script_row_t  script[$];
  out_beat_t    expected_tokens[$];
  field_state_t fs = StateReset;
  int           bytes_sent = 0;
  int           mismatches = 0;
  bit           bytes_done = 0;
  bit           calm = 0;
  bit           quiet_window = 0;

  csv_field_tokenizer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_beat   (byte_beat),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_beat  (token_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_beat(command_t cmd, logic [7:0] ch, bit typed = 1'b0,
                                   out_beat_t want = '0);
    script_row_t row;
    row.beat.command = cmd;
    row.beat.text_byte = ch;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  function automatic void add_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(CMD_TEXT, s[i]);
    end
  endfunction

  function automatic out_beat_t field_record(bit row, bit doc);
    out_beat_t rec;
    rec = '0;
    rec.kind = KIND_FIELD_END;
    rec.row_end = row;
    rec.doc_end = doc;
    if (!fs.field_started) begin
      rec.field_type = FT_EMPTY;
    end else if (fs.maybe_integer) begin
      rec.field_type = FT_INTEGER;
      if (fs.negative_sign) begin
        rec.int_value = fs.overflowed ? LimitMag : 64'd0 - fs.magnitude;
      end else if (fs.overflowed || fs.magnitude > MaxPos) begin
        rec.int_value = MaxPos;
      end else begin
        rec.int_value = fs.magnitude;
      end
    end else if (fs.maybe_float) begin
      rec.field_type = FT_FLOAT;
    end else if (fs.field_quoted) begin
      rec.field_type = FT_QUOTED;
    end else begin
      rec.field_type = FT_PLAIN;
    end
    return rec;
  endfunction

  function automatic bit tokenize_beat(in_beat_t b, output out_beat_t tok);
    logic [7:0]  c;
    logic [63:0] d;
    logic [63:0] base;
    bit          emit;
    bit          digit;
    bit          keep_quotes;
    c = b.text_byte;
    d = 64'(c) - 64'(CharZero);
    emit = 1'b0;
    tok = '0;
    if (b.command == CMD_DOC_END) begin
      if (fs.error_hold) begin
        fs = StateReset;
        return 1'b0;
      end
      if (fs.inside_quotes) begin
        tok.kind = KIND_ERROR;
        tok.doc_end = 1'b1;
      end else begin
        tok = field_record(1'b1, 1'b1);
      end
      fs = StateReset;
      return 1'b1;
    end
    if (fs.error_hold) return 1'b0;
    if (!fs.inside_quotes && (c == CharComma || c == CharNewline)) begin
      tok = field_record(c == CharNewline, 1'b0);
      keep_quotes = fs.inside_quotes;
      fs = StateReset;
      fs.inside_quotes = keep_quotes;
      return 1'b1;
    end
    if (c == CharQuote) begin
      if (!fs.field_started) fs.field_quoted = 1'b1;
      if (fs.field_quoted) begin
        if (!fs.inside_quotes && fs.field_started) emit = 1'b1;
        fs.inside_quotes = !fs.inside_quotes;
      end else begin
        emit = 1'b1;
      end
    end else if (fs.field_quoted && !fs.inside_quotes) begin
      fs.error_hold = 1'b1;
      tok.kind = KIND_ERROR;
      return 1'b1;
    end else begin
      emit = 1'b1;
    end

    digit = (c >= CharZero && c <= CharNine);
    if (fs.maybe_float && !digit && (fs.field_started || c != CharMinus)) begin
      if (c == CharDot) begin
        if (fs.maybe_integer) fs.maybe_integer = 1'b0;
        else fs.maybe_float = 1'b0;
      end else begin
        fs.maybe_integer = 1'b0;
        fs.maybe_float = 1'b0;
      end
    end
    if (fs.maybe_integer) begin
      if (digit) begin
        if (fs.radix_state == RADIX_NONE) begin
          if (d == 64'd0) fs.radix_state = RADIX_OCT;
          else fs.radix_state = RADIX_DEC;
          fs.magnitude = d;
        end else if (!fs.digits_stopped) begin
          base = (fs.radix_state == RADIX_OCT) ? 64'd8 : 64'd10;
          if (base == 64'd8 && d > 64'd7) begin
            fs.digits_stopped = 1'b1;
          end else if (!fs.overflowed) begin
            if (fs.magnitude > (LimitMag - d) / base) fs.overflowed = 1'b1;
            else fs.magnitude = fs.magnitude * base + d;
          end
        end
      end else if (c == CharMinus && !fs.field_started) begin
        fs.negative_sign = 1'b1;
      end
    end
    fs.field_started = 1'b1;

    if (emit) begin
      tok.kind = KIND_CONTENT;
      tok.content_byte = c;
    end
    return emit;
  endfunction

  initial begin : run_control
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (bytes_done);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("csv_field_tokenizer_top regression: pass");
    end else begin
      $display("csv_field_tokenizer_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < 2000) begin
      @(posedge clk);
      if (rst || (byte_valid && byte_ready) || (token_valid && token_ready)) quiet = 0;
      else quiet++;
    end
    $display("csv_field_tokenizer_top regression: fail");
    $finish;
  end

  initial begin : byte_source
    string     boundary_ints[10];
    int        nf;
    int        n;
    int        gap;
    logic [7:0] ch;
    out_beat_t tok;
    bit        accepted;

    boundary_ints = '{"9223372036854775807", "9223372036854775808",
                      "-9223372036854775808", "-9223372036854775809",
                      "0777777777777777777777", "01000000000000000000000",
                      "-01000000000000000000000", "0009", "00", "99999999999999999999"};
    byte_valid <= 1'b0;
    byte_beat <= '0;
    gap = 0;

    add_beat(CMD_DOC_END, 8'h00, 1'b1, out_beat_t'{KIND_FIELD_END, 8'h00, FT_EMPTY, 64'sd0,
                                                   1'b1, 1'b1});
    add_beat(CMD_TEXT, CharMinus, 1'b1, out_beat_t'{KIND_CONTENT, CharMinus, FT_EMPTY, 64'sd0,
                                                    1'b0, 1'b0});
    add_beat(CMD_TEXT, CharComma, 1'b1, out_beat_t'{KIND_FIELD_END, 8'h00, FT_INTEGER, 64'sd0,
                                                    1'b0, 1'b0});
    add_string("09");
    add_beat(CMD_TEXT, CharNewline);
    add_beat(CMD_TEXT, CharQuote);
    add_beat(CMD_TEXT, CharQuote);
    add_beat(CMD_TEXT, CharQuote);
    add_string("x");
    add_beat(CMD_TEXT, CharQuote);
    add_beat(CMD_TEXT, "y", 1'b1, out_beat_t'{KIND_ERROR, 8'h00, FT_EMPTY, 64'sd0, 1'b0, 1'b0});
    add_beat(CMD_TEXT, 8'hFF);
    add_beat(CMD_DOC_END, 8'h00);
    add_beat(CMD_TEXT, CharQuote);
    add_beat(CMD_DOC_END, 8'h00, 1'b1, out_beat_t'{KIND_ERROR, 8'h00, FT_EMPTY, 64'sd0,
                                                   1'b0, 1'b1});
    add_string("1.5,a");
    add_beat(CMD_TEXT, CharQuote);
    add_beat(CMD_TEXT, 8'h00);
    add_beat(CMD_TEXT, 8'hFF);
    add_beat(CMD_DOC_END, 8'hFF);

    while (script.size() < 1475) begin
      nf = $urandom_range(1, 12);
      for (int f = 0; f < nf; f++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            if ($urandom_range(0, 2) == 0) add_beat(CMD_TEXT, CharMinus);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 23) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
              if (i == 0 && $urandom_range(0, 3) == 0) add_beat(CMD_TEXT, CharZero);
              else add_beat(CMD_TEXT, CharZero + 8'($urandom_range(0, 9)));
            end
          end
          3: add_string(boundary_ints[$urandom_range(0, 9)]);
          4: begin
            if ($urandom_range(0, 2) == 0) add_beat(CMD_TEXT, CharMinus);
            repeat ($urandom_range(0, 4)) add_beat(CMD_TEXT, CharZero + 8'($urandom_range(0, 9)));
            add_beat(CMD_TEXT, CharDot);
            repeat ($urandom_range(0, 4)) add_beat(CMD_TEXT, CharZero + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0) add_string(".7");
          end
          5, 6: begin
            add_beat(CMD_TEXT, CharQuote);
            repeat ($urandom_range(0, 8)) begin
              case ($urandom_range(0, 9))
                0: begin
                  add_beat(CMD_TEXT, CharQuote);
                  add_beat(CMD_TEXT, CharQuote);
                end
                1: add_beat(CMD_TEXT, CharComma);
                2: add_beat(CMD_TEXT, CharNewline);
                default: begin
                  ch = 8'($urandom_range(8'h20, 8'h7E));
                  add_beat(CMD_TEXT, (ch == CharQuote) ? 8'h71 : ch);
                end
              endcase
            end
            if ($urandom_range(0, 19) != 0) add_beat(CMD_TEXT, CharQuote);
            if ($urandom_range(0, 9) == 0) add_beat(CMD_TEXT, 8'($urandom_range(0, 255)));
          end
          7: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
              ch = 8'($urandom_range(0, 255));
              if (ch == CharComma || ch == CharNewline || (i == 0 && ch == CharQuote)) ch = 8'h62;
              add_beat(CMD_TEXT, ch);
            end
          end
          8: ;
          default: repeat ($urandom_range(1, 4)) add_beat(CMD_TEXT, 8'($urandom_range(0, 255)));
        endcase
        if (f < nf - 1) add_beat(CMD_TEXT, ($urandom_range(0, 3) == 0) ? CharNewline : CharComma);
      end
      case ($urandom_range(0, 7))
        0: add_beat(CMD_TEXT, CharNewline);
        1: add_beat(CMD_TEXT, CharComma);
        default: ;
      endcase
      add_beat(CMD_DOC_END, 8'($urandom_range(0, 255)));
    end

    do @(posedge clk); while (rst);
    while (bytes_sent < script.size()) begin
      accepted = byte_valid && byte_ready;
      if (accepted) begin
        if (tokenize_beat(script[bytes_sent].beat, tok)) begin
          expected_tokens.push_back(script[bytes_sent].typed ? script[bytes_sent].want : tok);
        end
        bytes_sent++;
        calm = (bytes_sent + 150 >= script.size());
        quiet_window = ((bytes_sent / 200) % 3 == 2);
      end
      if (accepted || !byte_valid) begin
        if (bytes_sent == script.size()) begin
          byte_valid <= 1'b0;
        end else if (gap > 0) begin
          gap--;
          byte_valid <= 1'b0;
        end else if (!calm && !quiet_window && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 6) - 1;
          byte_valid <= 1'b0;
        end else begin
          byte_valid <= 1'b1;
          byte_beat <= script[bytes_sent].beat;
        end
      end
      @(posedge clk);
    end
    bytes_done = 1'b1;
  end

  initial begin : token_sink
    int        stall;
    int        hold;
    bit        held;
    out_beat_t want;

    stall = 0;
    hold = 0;
    held = 1'b0;
    token_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token beat with no expected result: kind %0d", token_beat.kind);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_beat.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, token_beat.kind);
            mismatches++;
          end
          if (token_beat.content_byte !== want.content_byte) begin
            $error("content_byte: expected %0h, actual %0h", want.content_byte,
                   token_beat.content_byte);
            mismatches++;
          end
          if (token_beat.field_type !== want.field_type) begin
            $error("field_type: expected %0d, actual %0d", want.field_type,
                   token_beat.field_type);
            mismatches++;
          end
          if (token_beat.int_value !== want.int_value) begin
            $error("int_value: expected %0d, actual %0d", want.int_value, token_beat.int_value);
            mismatches++;
          end
          if (token_beat.row_end !== want.row_end) begin
            $error("row_end: expected %0d, actual %0d", want.row_end, token_beat.row_end);
            mismatches++;
          end
          if (token_beat.doc_end !== want.doc_end) begin
            $error("doc_end: expected %0d, actual %0d", want.doc_end, token_beat.doc_end);
            mismatches++;
          end
        end
      end
      if (!held && bytes_sent >= 400) begin
        held = 1'b1;
        hold = 200;
      end
      if (hold > 0) begin
        hold--;
        token_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        token_ready <= 1'b0;
      end else if (!calm && !quiet_window && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 6) - 1;
        token_ready <= 1'b0;
      end else begin
        token_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

endmodule
